/* rtl/med_pkg.sv */
// Package for the masked Euclidean distance block: widths, item types, sequencer states.
// Has no dependencies. The interfaces and the top level import it.
`default_nettype none

package med_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int ABS_W    = SAMPLE_W;
	localparam int SQ_W     = 2 * ABS_W;
	localparam int SUM_W    = 42;
	localparam int CNT_W    = 11;
	localparam int DIST_W   = 21;
	localparam int REM_W    = DIST_W + 3;
	localparam int STEP_W   = 5;

	localparam logic [CNT_W-1:0]  MAX_DIMS  = CNT_W'(1024);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIST_W - 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a_sample;
		logic signed [SAMPLE_W-1:0] b_sample;
		logic                       a_missing;
		logic                       b_missing;
		logic                       last_element;
	} med_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              distance_valid;
	} med_out_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_ACC  = 6'b000100,
		ST_ROOT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} med_state_t;

endpackage

`default_nettype wire

/* rtl/med_if.sv */
// Handshake channels of the masked Euclidean distance block: sample pairs in, distance out.
// Depends on med_pkg for field widths.
`default_nettype none

interface med_in_if
	import med_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] a_sample;
	logic signed [SAMPLE_W-1:0] b_sample;
	logic                       a_missing;
	logic                       b_missing;
	logic                       last_element;

	modport source (
		output valid, a_sample, b_sample, a_missing, b_missing, last_element,
		input  ready
	);
	modport sink (
		input  valid, a_sample, b_sample, a_missing, b_missing, last_element,
		output ready
	);
endinterface

interface med_out_if
	import med_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              distance_valid;

	modport source (
		output valid, distance, distance_valid,
		input  ready
	);
	modport sink (
		input  valid, distance, distance_valid,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/masked_euclidean_distance.sv */
// Masked Euclidean distance: one shared subtractor serves the square root and the divide.
// Depends on med_pkg and the channel interfaces in med_if.sv.
// Each element is captured, squared and accumulated before the next one is accepted.
// A last element with a dimension used adds 21 square-root steps and 21 divide steps;
// then the output register is loaded once it is free or being taken; with no usable dimension both are skipped.
// The output register holds a result until taken; reset clears the sum, the count and the output valid flag.
`default_nettype none

module masked_euclidean_distance
	import med_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	med_in_if.sink     samples,
	med_out_if.source  result
);

	med_state_t                 state_q;
	med_in_t                    item_q;
	logic                       use_q;
	logic [SQ_W-1:0]            prod_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [REM_W-1:0]           rem_q;
	logic [DIST_W-1:0]          root_q;
	logic [STEP_W-1:0]          step_q;
	logic                       out_valid_q;
	med_out_t                   out_q;

	logic                       accept;
	logic signed [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]          diff_abs;
	logic [REM_W-1:0]           sub_a;
	logic [REM_W-1:0]           sub_b;
	logic [REM_W:0]             sub_r;
	logic                       sub_ge;
	logic                       out_load;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;

	assign diff     = DIFF_W'(item_q.b_sample) - DIFF_W'(item_q.a_sample);
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	always_comb begin
		if (state_q == ST_ROOT) begin
			sub_a = {rem_q[REM_W-3:0], sum_q[SUM_W-1 -: 2]};
			sub_b = {1'b0, root_q, 2'b01};
		end else begin
			sub_a = {rem_q[REM_W-2:0], root_q[DIST_W-1]};
			sub_b = REM_W'(cnt_q);
		end
		sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_r[REM_W];
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (use_q) begin
						sum_q <= sum_q + SUM_W'(prod_q);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					step_q <= '0;
					if (!item_q.last_element) begin
						state_q <= ST_IDLE;
					end else if (!use_q && cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					sum_q <= sum_q << 2;
					if (step_q == LAST_STEP) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.a_sample     <= samples.a_sample;
			item_q.b_sample     <= samples.b_sample;
			item_q.a_missing    <= samples.a_missing;
			item_q.b_missing    <= samples.b_missing;
			item_q.last_element <= samples.last_element;
			use_q <= !samples.a_missing && !samples.b_missing && (cnt_q < MAX_DIMS);
		end
		if (state_q == ST_MUL) begin
			prod_q <= diff_abs[ABS_W-1:0] * diff_abs[ABS_W-1:0];
		end
		if (state_q == ST_ACC) begin
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == ST_ROOT) begin
			root_q <= {root_q[DIST_W-2:0], sub_ge};
			if (step_q == LAST_STEP) begin
				rem_q <= '0;
			end else begin
				rem_q <= sub_ge ? sub_r[REM_W-1:0] : sub_a;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q  <= sub_ge ? sub_r[REM_W-1:0] : sub_a;
			root_q <= {root_q[DIST_W-2:0], sub_ge};
		end
		if (out_load) begin
			out_q.distance       <= root_q;
			out_q.distance_valid <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.distance       = out_q.distance;
	assign result.distance_valid = out_q.distance_valid;

`ifndef SYNTH
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !samples.ready)
		else $error("block ready straight after an input transfer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_DIMS)
		else $error("usable count beyond its limit");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.distance_valid |-> result.distance == '0)
		else $error("invalid result with nonzero distance");

	a_root_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> rem_q[REM_W-1:REM_W-2] == 2'b00)
		else $error("square-root remainder out of range");

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < REM_W'(cnt_q))
		else $error("divide remainder not below the count");
`endif

endmodule

`default_nettype wire

/* tb/tb_masked_euclidean_distance.sv */
// Testbench for masked_euclidean_distance: streams vector pairs with random gaps and stalls,
// predicts each distance in a scoreboard class and compares it field by field.
// Depends on med_pkg and the channel interfaces in med_if.sv.
`timescale 1ns / 1ps

module tb_masked_euclidean_distance
	import med_pkg::*;
();

	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 750;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 60;

	class distance_scoreboard;
		logic [SUM_W-1:0] square_total;
		logic [CNT_W-1:0] used_dims;
		med_out_t         expected_q[$];
		int               failures;

		function new();
			square_total = '0;
			used_dims    = '0;
			failures     = 0;
		endfunction

		function longint unsigned floor_root(longint unsigned x);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= x)
					root = trial;
			end
			return root;
		endfunction

		function void note_sample(med_in_t item);
			int               a_val;
			int               b_val;
			int               diff;
			longint unsigned  mag;
			med_out_t         want;
			if (!item.a_missing && !item.b_missing && used_dims < MAX_DIMS) begin
				a_val = int'(item.a_sample);
				b_val = int'(item.b_sample);
				diff  = b_val - a_val;
				mag   = 64'((diff < 0) ? -diff : diff);
				square_total += SUM_W'(mag * mag);
				used_dims    += CNT_W'(1);
			end
			if (item.last_element) begin
				if (used_dims == 0) begin
					want.distance       = '0;
					want.distance_valid = 1'b0;
				end else begin
					want.distance       = DIST_W'(floor_root(64'(square_total)) / 64'(used_dims));
					want.distance_valid = 1'b1;
				end
				expected_q = {expected_q, want};
				square_total = '0;
				used_dims    = '0;
			end
		endfunction

		function void check_distance(med_out_t got);
			med_out_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: distance %0d distance_valid %0d",
					got.distance, got.distance_valid);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.distance !== want.distance) begin
				$error("distance: expected %0d, actual %0d", want.distance, got.distance);
				failures++;
			end
			if (got.distance_valid !== want.distance_valid) begin
				$error("distance_valid: expected %0d, actual %0d",
					want.distance_valid, got.distance_valid);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   send_quiet;
	int   recv_quiet;

	distance_scoreboard sb = new();

	med_in_if  samples_ch();
	med_out_if result_ch();

	masked_euclidean_distance i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_gap(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = int'($urandom_range(10, 40));
			return 0;
		end
		return int'($urandom_range(0, 14));
	endfunction

	function automatic med_in_t make_element(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
		logic a_miss, logic b_miss, logic last);
		med_in_t item;
		item.a_sample     = a;
		item.b_sample     = b;
		item.a_missing    = a_miss;
		item.b_missing    = b_miss;
		item.last_element = last;
		return item;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_sample(input med_in_t item);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.a_sample     <= item.a_sample;
		samples_ch.b_sample     <= item.b_sample;
		samples_ch.a_missing    <= item.a_missing;
		samples_ch.b_missing    <= item.b_missing;
		samples_ch.last_element <= item.last_element;
		do @(posedge clk); while (!samples_ch.ready);
		sb.note_sample(item);
		@(negedge clk);
	endtask

	task automatic send_vector(input int dims, input int miss_pct);
		for (int i = 0; i < dims; i++) begin
			send_sample(make_element(pick_value(), pick_value(),
				$urandom_range(0, 99) < miss_pct, $urandom_range(0, 99) < miss_pct,
				i == dims - 1));
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("masked_euclidean_distance verification failed");
		$finish;
	end

	initial begin
		int  taken;
		int  hold;
		bit  held;
		taken = 0;
		held  = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!held && taken == 25) begin
				held = 1'b1;
				hold = LONG_HOLD;
			end else begin
				hold = draw_gap(recv_quiet);
			end
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_distance('{distance: result_ch.distance,
				distance_valid: result_ch.distance_valid});
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		int sent;
		int dims;
		int miss_pct;
		int long_dims;
		bit long_done;
		cycle_count             = 0;
		send_quiet              = 0;
		recv_quiet              = 0;
		arst_n                  = 1'b0;
		samples_ch.valid        = 1'b0;
		samples_ch.a_sample     = '0;
		samples_ch.b_sample     = '0;
		samples_ch.a_missing    = 1'b0;
		samples_ch.b_missing    = 1'b0;
		samples_ch.last_element = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(make_element(16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b1));
		send_sample(make_element(16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b1));
		send_sample(make_element(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1));
		send_sample(make_element(16'd5, 16'd9, 1'b1, 1'b0, 1'b1));
		send_sample(make_element(16'd5, 16'd9, 1'b0, 1'b1, 1'b1));
		send_sample(make_element(16'd256, 16'd256, 1'b0, 1'b0, 1'b1));
		send_sample(make_element(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1));
		// missing final dimension still closes the vector
		send_sample(make_element(16'd0, 16'd256, 1'b0, 1'b0, 1'b0));
		send_sample(make_element(16'd256, 16'd0, 1'b0, 1'b0, 1'b0));
		send_sample(make_element(16'd100, 16'd200, 1'b1, 1'b0, 1'b1));
		// no usable dimension across several elements
		send_sample(make_element(16'd1000, 16'hFC18, 1'b0, 1'b1, 1'b0));
		send_sample(make_element(16'd7, 16'd7, 1'b1, 1'b1, 1'b0));
		send_sample(make_element(16'd3, 16'd4, 1'b1, 1'b0, 1'b1));
		for (int i = 0; i < 4; i++)
			send_sample(make_element(16'h7FFF, 16'h8000, 1'b0, 1'b0, i == 3));
		send_sample(make_element(16'd0, 16'd3, 1'b0, 1'b0, 1'b0));
		send_sample(make_element(16'd0, 16'd4, 1'b0, 1'b0, 1'b1));

		sent      = 0;
		long_done = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (!long_done && sent >= 200) begin
				// overrun the dimension limit
				long_done = 1'b1;
				long_dims = int'(MAX_DIMS) + int'($urandom_range(64, 80));
				send_vector(long_dims, 0);
				sent += long_dims;
			end
			dims = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			case ($urandom_range(0, 5))
				0:       miss_pct = 0;
				1:       miss_pct = 100;
				2:       miss_pct = 60;
				default: miss_pct = 15;
			endcase
			send_vector(dims, miss_pct);
			sent += dims;
		end
		samples_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("masked_euclidean_distance verification clean");
		else
			$display("masked_euclidean_distance verification failed");
		$finish;
	end

endmodule
